>>> rtl/bdq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

  localparam int BDQ_MAX_HALF   = 512;  // default largest half capacity
  localparam int BDQ_RESET_HALF = 512;  // half capacity after reset
  localparam int BDQ_CFG_W      = 10;   // width of the configuration word
  localparam int BDQ_DATA_W     = 32;   // width of one stored word

  typedef enum logic [1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_BACK  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_BACK   = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Per-cycle instruction broadcast to every cell of a row
  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_SHR   = 2'd1,
    OP_SHL   = 2'd2,
    OP_WRITE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t              op;
    logic [BDQ_DATA_W-1:0] data;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/bounded_array_deque_core.sv
`timescale 1ns / 1ps
`default_nettype none

// The out_valid strobe rises in the cycle after the start edge.
// Throughput: one transaction every cycle; busy is never raised.
// Two rows of 2*MAX_HALF shift cells hold the deque, one headed at each end,
// so every pop reads a fixed cell and each row takes one shift or one write per update.
// Reset (synchronous, rst_n low) sets half capacity to 512 and empties the
// deque; stored words are not cleared. The receiver cannot stall the results.

module bounded_array_deque_core
  import bdq_pkg::*;
#(
  parameter int MAX_HALF = BDQ_MAX_HALF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // command channel
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic        [1:0]            in_action,
  input  wire logic signed [BDQ_DATA_W-1:0] in_value,
  // result channel
  output logic                              out_valid,
  output logic signed      [BDQ_DATA_W-1:0] out_popped_value,
  output logic             [1:0]            out_status,
  output logic                              out_is_empty,
  output logic                              out_is_full,
  // configuration
  input  wire logic                         cfg_we,
  input  wire logic        [BDQ_CFG_W-1:0]  cfg_wdata
);

  localparam int HW       = $clog2(MAX_HALF + 1);       // half capacity width
  localparam int PW       = HW + 1;                     // position width, 0..2*MAX_HALF
  localparam int DEPTH    = 2 * MAX_HALF;               // cells per row
  localparam int IW       = $clog2(DEPTH);              // cell index width
  localparam int CMPW     = (HW > BDQ_CFG_W) ? HW : BDQ_CFG_W;
  localparam int RST_HALF = (BDQ_RESET_HALF > MAX_HALF) ? MAX_HALF : BDQ_RESET_HALF;

  // Positions: front_r is the front index, end_r is one past the back index.
  logic [HW-1:0] half_r, half_nxt;
  logic [PW-1:0] front_r, front_nxt;
  logic [PW-1:0] end_r, end_nxt;

  logic                  out_valid_r;
  logic [BDQ_DATA_W-1:0] popped_r, popped_nxt;
  status_t               status_r, status_nxt;
  logic                  empty_r, full_r;

  logic                  accept;
  act_t                  act;
  logic [PW-1:0]         two_h;
  logic [PW-1:0]         count;
  logic                  cur_full;
  logic                  cur_empty;
  logic [CMPW-1:0]       cfg_ext;
  cell_ctl_t             fwd_ctl, rev_ctl;
  logic [BDQ_DATA_W-1:0] fwd_head, rev_head;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign act    = act_t'(in_action);

  assign two_h     = {half_r, 1'b0};
  assign count     = end_r - front_r;
  assign cur_full  = (front_r == '0) || (end_r >= two_h);
  assign cur_empty = (front_r == end_r);

  // Clamp the written half capacity into 1..MAX_HALF
  assign cfg_ext = CMPW'(cfg_wdata);
  always_comb begin
    if (cfg_ext == '0) begin
      half_nxt = HW'(1);
    end else if (cfg_ext > CMPW'(MAX_HALF)) begin
      half_nxt = HW'(MAX_HALF);
    end else begin
      half_nxt = HW'(cfg_ext);
    end
  end

  // Decode one transaction: position update, row instructions, result.
  // The forward row has the front word in cell 0, the reverse row the back word.
  always_comb begin
    front_nxt    = front_r;
    end_nxt      = end_r;
    popped_nxt   = '0;
    status_nxt   = ST_DONE;
    fwd_ctl.op   = OP_HOLD;
    fwd_ctl.data = in_value;
    rev_ctl.op   = OP_HOLD;
    rev_ctl.data = in_value;

    if (accept) begin
      unique case (act)
        ACT_PUSH_FRONT: begin
          if (cur_full) begin
            status_nxt = ST_FULL;
          end else begin
            front_nxt  = front_r - PW'(1);
            fwd_ctl.op = OP_SHR;     // insert at the head
            rev_ctl.op = OP_WRITE;   // land after the current front word
          end
        end
        ACT_PUSH_BACK: begin
          if (cur_full) begin
            status_nxt = ST_FULL;
          end else begin
            end_nxt    = end_r + PW'(1);
            rev_ctl.op = OP_SHR;
            fwd_ctl.op = OP_WRITE;
          end
        end
        ACT_POP_FRONT: begin
          if (cur_empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            popped_nxt = fwd_head;
            front_nxt  = front_r + PW'(1);
            fwd_ctl.op = OP_SHL;     // drop the head; the reverse row just shrinks
          end
        end
        ACT_POP_BACK: begin
          if (cur_empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            popped_nxt = rev_head;
            end_nxt    = end_r - PW'(1);
            rev_ctl.op = OP_SHL;
          end
        end
        default: begin
          status_nxt = ST_DONE;
        end
      endcase
    end
  end

  bdq_row #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_fwd_row (
    .clk      (clk),
    .ctl_i    (fwd_ctl),
    .wr_idx_i (count[IW-1:0]),
    .head_o   (fwd_head)
  );

  bdq_row #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_rev_row (
    .clk      (clk),
    .ctl_i    (rev_ctl),
    .wr_idx_i (count[IW-1:0]),
    .head_o   (rev_head)
  );

  // Control state: half capacity and positions; a configuration write wins
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r      <= HW'(RST_HALF);
      front_r     <= PW'(RST_HALF);
      end_r       <= PW'(RST_HALF);
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (cfg_we) begin
        half_r  <= half_nxt;
        front_r <= {1'b0, half_nxt};
        end_r   <= {1'b0, half_nxt};
      end else begin
        front_r <= front_nxt;
        end_r   <= end_nxt;
      end
    end
  end

  // Result payload, flags taken from the updated positions
  always_ff @(posedge clk) begin
    if (accept) begin
      popped_r <= popped_nxt;
      status_r <= status_nxt;
      empty_r  <= (front_nxt == end_nxt);
      full_r   <= (front_nxt == '0) || (end_nxt >= two_h);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = popped_r;
  assign out_status       = status_r;
  assign out_is_empty     = empty_r;
  assign out_is_full      = full_r;

`ifndef SYNTHESIS
  // The front never passes one beyond the back
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    front_r <= end_r)
    else $error("front position beyond back");

  // The back never runs past the store limit
  a_limit: assert property (@(posedge clk) disable iff (!rst_n)
    end_r <= two_h)
    else $error("back position beyond limit");

  // Exactly one result per transaction, in the cycle after it
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("transaction without result");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_valid)
    else $error("result without transaction");

  // A refused push leaves the positions alone
  a_refused_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !cfg_we && cur_full &&
     (act == ACT_PUSH_FRONT || act == ACT_PUSH_BACK))
    |=> ($stable(front_r) && $stable(end_r)))
    else $error("refused push moved a position");

  // Only a completed pop reports a word
  a_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_DONE) |-> (out_popped_value == '0))
    else $error("refused transaction reported a word");
`endif

endmodule

`default_nettype wire

>>> rtl/bdq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module bdq_cell
  import bdq_pkg::*;
#(
  parameter int IW  = $clog2(2 * BDQ_MAX_HALF),
  parameter int IDX = 0
) (
  input  wire logic                  clk,
  input  wire cell_ctl_t             ctl_i,
  input  wire logic [IW-1:0]         wr_idx_i,
  input  wire logic [BDQ_DATA_W-1:0] left_i,
  input  wire logic [BDQ_DATA_W-1:0] right_i,
  output logic      [BDQ_DATA_W-1:0] data_o
);

  logic [BDQ_DATA_W-1:0] data_r;

  // Take the neighbor's word on a shift, or the broadcast word when addressed
  always_ff @(posedge clk) begin
    unique case (ctl_i.op)
      OP_SHR:   data_r <= left_i;
      OP_SHL:   data_r <= right_i;
      OP_WRITE: begin
        if (wr_idx_i == IW'(IDX)) begin
          data_r <= ctl_i.data;
        end
      end
      default:  data_r <= data_r;
    endcase
  end

  assign data_o = data_r;

endmodule

`default_nettype wire

>>> rtl/bdq_row.sv
`timescale 1ns / 1ps
`default_nettype none

module bdq_row
  import bdq_pkg::*;
#(
  parameter int DEPTH = 2 * BDQ_MAX_HALF,
  parameter int IW    = $clog2(2 * BDQ_MAX_HALF)
) (
  input  wire logic                  clk,
  input  wire cell_ctl_t             ctl_i,
  input  wire logic [IW-1:0]         wr_idx_i,
  output logic      [BDQ_DATA_W-1:0] head_o
);

  logic [BDQ_DATA_W-1:0] cell_q [DEPTH];

  // Cell 0 is the head; a right shift feeds it the broadcast word
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [BDQ_DATA_W-1:0] left_w;
    logic [BDQ_DATA_W-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = ctl_i.data;
    end else begin : g_inner_l
      assign left_w = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner_r
      assign right_w = cell_q[i+1];
    end

    bdq_cell #(
      .IW  (IW),
      .IDX (i)
    ) u_cell (
      .clk      (clk),
      .ctl_i    (ctl_i),
      .wr_idx_i (wr_idx_i),
      .left_i   (left_w),
      .right_i  (right_w),
      .data_o   (cell_q[i])
    );
  end

  assign head_o = cell_q[0];

endmodule

`default_nettype wire

>>> tb/sv/bdq_result_checker.sv
`timescale 1ns / 1ps

module bdq_result_checker
  import bdq_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic                         busy,
  input  wire logic        [1:0]            in_action,
  input  wire logic signed [BDQ_DATA_W-1:0] in_value,
  input  wire logic                         out_valid,
  input  wire logic signed [BDQ_DATA_W-1:0] out_popped_value,
  input  wire logic        [1:0]            out_status,
  input  wire logic                         out_is_empty,
  input  wire logic                         out_is_full,
  input  wire logic                         cfg_we,
  input  wire logic        [BDQ_CFG_W-1:0]  cfg_wdata,
  output int                                mismatch_count,
  output int                                open_outcomes
);

  localparam int STORE_DEPTH = 2 * BDQ_MAX_HALF;

  typedef struct packed {
    logic [BDQ_DATA_W-1:0] popped_value;
    status_t               status;
    logic                  is_empty;
    logic                  is_full;
  } deque_outcome_t;

  logic [BDQ_DATA_W-1:0] shadow_words [STORE_DEPTH];
  int                    half_cap;
  int                    front_pos;
  int                    back_pos;
  deque_outcome_t        outcome_q [$];

  function automatic bit shadow_empty();
    return front_pos > back_pos;
  endfunction

  function automatic bit shadow_full();
    return front_pos <= 0 || back_pos >= 2 * half_cap - 1;
  endfunction

  // Apply one operation to the shadow deque and return what the block must report.
  function automatic deque_outcome_t predict_deque_op(act_t op, logic [BDQ_DATA_W-1:0] word);
    deque_outcome_t res;
    res = '0;
    res.status = ST_DONE;
    case (op)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (shadow_full()) begin
          res.status = ST_FULL;
        end else if (op == ACT_PUSH_FRONT) begin
          front_pos--;
          shadow_words[front_pos] = word;
        end else begin
          back_pos++;
          shadow_words[back_pos] = word;
        end
      end
      default: begin
        if (shadow_empty()) begin
          res.status = ST_EMPTY;
        end else if (op == ACT_POP_FRONT) begin
          res.popped_value = shadow_words[front_pos];
          front_pos++;
        end else begin
          res.popped_value = shadow_words[back_pos];
          back_pos--;
        end
      end
    endcase
    res.is_empty = shadow_empty();
    res.is_full  = shadow_full();
    return res;
  endfunction

  task automatic note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("[%0t] deque check failed: %s", $realtime, msg);
    end
  endtask

  task automatic check_field(string field, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      note_mismatch($sformatf("%s expected 0x%08h got 0x%08h", field, exp_v, got_v));
    end
  endtask

  always @(posedge clk) begin : watch
    deque_outcome_t exp_o;
    if (!rst_n) begin
      half_cap  = BDQ_RESET_HALF;
      front_pos = half_cap;
      back_pos  = half_cap - 1;
      outcome_q.delete();
    end else begin
      if (out_valid === 1'b1) begin
        if (outcome_q.size() == 0) begin
          note_mismatch("result strobe with no transaction outstanding");
        end else begin
          exp_o = outcome_q.pop_front();
          check_field("popped_value", exp_o.popped_value, out_popped_value);
          check_field("status", 32'(exp_o.status), 32'(out_status));
          check_field("is_empty", 32'(exp_o.is_empty), 32'(out_is_empty));
          check_field("is_full", 32'(exp_o.is_full), 32'(out_is_full));
        end
      end
      if (cfg_we === 1'b1) begin
        if (cfg_wdata == '0) begin
          half_cap = 1;
        end else if (cfg_wdata > BDQ_MAX_HALF) begin
          half_cap = BDQ_MAX_HALF;
        end else begin
          half_cap = int'(cfg_wdata);
        end
        front_pos = half_cap;
        back_pos  = half_cap - 1;
      end
      if (start === 1'b1 && busy === 1'b0) begin
        outcome_q.push_back(predict_deque_op(act_t'(in_action), in_value));
      end
    end
    open_outcomes = outcome_q.size();
  end

endmodule

>>> tb/sv/bounded_array_deque_core_tb.sv
`timescale 1ns / 1ps

module bounded_array_deque_core_tb;
  import bdq_pkg::*;

  logic                         clk       = 1'b0;
  logic                         rst_n     = 1'b0;
  logic                         start     = 1'b0;
  logic                         busy;
  logic        [1:0]            in_action = ACT_PUSH_FRONT;
  logic signed [BDQ_DATA_W-1:0] in_value  = '0;
  logic                         out_valid;
  logic signed [BDQ_DATA_W-1:0] out_popped_value;
  logic        [1:0]            out_status;
  logic                         out_is_empty;
  logic                         out_is_full;
  logic                         cfg_we    = 1'b0;
  logic        [BDQ_CFG_W-1:0]  cfg_wdata = '0;

  int mismatch_count;
  int open_outcomes;
  // Chance, in percent, that the sender idles once more before a transaction
  int gap_pct = 0;

  always #4 clk = ~clk;

  bounded_array_deque_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_popped_value (out_popped_value),
    .out_status       (out_status),
    .out_is_empty     (out_is_empty),
    .out_is_full      (out_is_full),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  bdq_result_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_popped_value (out_popped_value),
    .out_status       (out_status),
    .out_is_empty     (out_is_empty),
    .out_is_full      (out_is_full),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .mismatch_count   (mismatch_count),
    .open_outcomes    (open_outcomes)
  );

  // Drive one transaction. Idle cycles come first, each dropping start on its own
  // falling edge, so start is never lowered and raised in the same time step.
  // Hold the command until a rising edge sees busy low.
  task automatic send_op(act_t op, logic [BDQ_DATA_W-1:0] word);
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start     <= 1'b1;
    in_action <= op;
    in_value  <= word;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start and wait until every transaction has reported back. Each
  // transaction yields exactly one result, so a short margin covers the pipeline.
  task automatic quiesce();
    @(negedge clk);
    start <= 1'b0;
    wait (open_outcomes == 0);
    repeat (2) @(posedge clk);
  endtask

  // Reload half capacity while the block is idle; this also empties the deque.
  task automatic load_half_capacity(logic [BDQ_CFG_W-1:0] cap);
    quiesce();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random transactions: push_pct steers fill level, front_pct steers which end.
  // Extreme words show up often so sign and boundary patterns get through the store.
  task automatic run_phase(int n, int idle, int push_pct, int front_pct);
    act_t                  op;
    logic [BDQ_DATA_W-1:0] word;
    bit                    push_op;
    bit                    front_end;
    gap_pct = idle;
    repeat (n) begin
      push_op   = $urandom_range(99) < push_pct;
      front_end = $urandom_range(99) < front_pct;
      if (push_op) begin
        op = front_end ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
      end else begin
        op = front_end ? ACT_POP_FRONT : ACT_POP_BACK;
      end
      case ($urandom_range(7))
        0:       word = 32'h8000_0000;
        1:       word = 32'h7fff_ffff;
        2:       word = '0;
        3:       word = '1;
        default: word = $urandom();
      endcase
      send_op(op, word);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset capacity: refused pops on an empty deque, then both ends with
    // extreme words, drained until empty again.
    send_op(ACT_POP_FRONT, 32'h1234_5678);
    send_op(ACT_POP_BACK, 32'h8765_4321);
    send_op(ACT_PUSH_FRONT, 32'h8000_0000);
    send_op(ACT_PUSH_BACK, 32'h7fff_ffff);
    send_op(ACT_PUSH_FRONT, 32'h0000_0000);
    send_op(ACT_PUSH_BACK, 32'hffff_ffff);
    send_op(ACT_POP_FRONT, '0);
    send_op(ACT_POP_BACK, '0);
    send_op(ACT_POP_FRONT, '0);
    send_op(ACT_POP_FRONT, '0);
    send_op(ACT_POP_BACK, '0);

    // Smallest capacity: one push at the back exhausts it, further pushes are
    // refused, and the deque stays flagged full even once drained.
    load_half_capacity(BDQ_CFG_W'(1));
    send_op(ACT_PUSH_BACK, 32'hdead_beef);
    send_op(ACT_PUSH_FRONT, 32'h0bad_f00d);
    send_op(ACT_POP_FRONT, '0);
    send_op(ACT_POP_BACK, '0);
    send_op(ACT_PUSH_FRONT, 32'h0000_0001);

    // Zero clamps up to one; exhaust the front end this time.
    load_half_capacity('0);
    send_op(ACT_PUSH_FRONT, 32'h5a5a_5a5a);
    send_op(ACT_PUSH_BACK, 32'h0000_0002);
    send_op(ACT_POP_BACK, '0);
    send_op(ACT_POP_FRONT, '0);

    // Just above the largest capacity clamps down to it.
    load_half_capacity(BDQ_CFG_W'(513));
    send_op(ACT_PUSH_BACK, 32'ha5a5_a5a5);
    send_op(ACT_POP_BACK, '0);

    // Random phases: mostly small capacities so both ends get exhausted often,
    // with the sender idling at different rates.
    load_half_capacity(BDQ_CFG_W'(3));
    run_phase(60, 0, 55, 50);
    load_half_capacity(BDQ_CFG_W'(7));
    run_phase(60, 63, 50, 50);
    load_half_capacity(BDQ_CFG_W'($urandom_range(16, 1)));
    run_phase(60, 13, 60, 30);
    load_half_capacity(BDQ_CFG_W'($urandom_range(1023)));
    run_phase(40, 0, 50, 50);

    // Top of the config range clamps to the largest capacity; push mostly at
    // the front so the front index walks all the way down to zero.
    load_half_capacity('1);
    run_phase(560, 13, 99, 99);

    load_half_capacity(BDQ_CFG_W'(2));
    run_phase(40, 0, 50, 50);

    quiesce();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && open_outcomes == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Guard against a hung handshake or a result that never shows up.
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
